FILE: rtl/mcdr_pkg.sv
// Shared types and constants for the motor command deframer and ramp block.
`timescale 1ns / 1ps

package mcdr_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'h55;
  localparam logic [7:0] HDR_BYTE1 = 8'hAA;
  localparam logic [7:0] CMD_ID_DRIVE = 8'd2;
  localparam logic [7:0] DRIVE_MODE_STOP = 8'd0;

  localparam int unsigned PAYLOAD_DEPTH = 6;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_STEP_PERIOD = 2'd1;
  localparam logic [1:0] REG_COMMAND_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

  // Configuration reset values
  localparam logic [7:0] STEP_SIZE_RST = 8'd5;
  localparam logic [15:0] STEP_PERIOD_RST = 16'd20;
  localparam logic [15:0] COMMAND_TIMEOUT_RST = 16'd10000;
  localparam logic [14:0] SPEED_LIMIT_RST = 15'd255;

  typedef struct packed {
    logic       mode;     // 0 serial byte, 1 tick
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic [7:0]         drive_mode;
    logic               command_accepted;
    logic               checksum_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  step_size;
    logic [15:0] step_period;
    logic [15:0] command_timeout;
    logic [14:0] speed_limit;
  } cfg_t;

  // Deframer to ramp: a frame that just completed
  typedef struct packed {
    logic               accepted;
    logic               bad_sum;
    logic [7:0]         mode;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } cmd_t;

endpackage

FILE: rtl/motor_command_deframer_ramp.sv
// Top level: input register, config registers, deframer, ramp and result register.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid / in_stall   in_item_t  (mode, rx_byte)
//   out_     output     out_valid / out_stall out_item_t (drives, mode, flags)
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One item per cycle when the result side takes results; each item passes through
// the input register, then the state update into the result register.
// Each item updates deframer and ramp state in the single cycle it leaves the
// input register; one result per item.
// rst_n (synchronous) clears frame search, targets, drives and timers, and
// loads the config defaults.
// out_stall holds the result register; in_stall rises only when both are full.
`timescale 1ns / 1ps

module motor_command_deframer_ramp
  import mcdr_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;

  logic               advance;
  logic               tick;
  cmd_t               cmd;
  logic signed [15:0] left_nxt, right_nxt;
  logic [7:0]         mode_nxt;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign tick      = in_item_r.mode;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size       <= STEP_SIZE_RST;
      cfg_r.step_period     <= STEP_PERIOD_RST;
      cfg_r.command_timeout <= COMMAND_TIMEOUT_RST;
      cfg_r.speed_limit     <= SPEED_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_SIZE:       cfg_r.step_size       <= cfg_wdata[7:0];
        REG_STEP_PERIOD:     cfg_r.step_period     <= cfg_wdata;
        REG_COMMAND_TIMEOUT: cfg_r.command_timeout <= cfg_wdata;
        REG_SPEED_LIMIT:     cfg_r.speed_limit     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  mcdr_deframer #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_deframer (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_en(advance && !tick),
    .rx_byte(in_item_r.rx_byte),
    .cmd    (cmd)
  );

  mcdr_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_en  (advance),
    .tick     (tick),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .left_nxt (left_nxt),
    .right_nxt(right_nxt),
    .mode_nxt (mode_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.left_drive       <= left_nxt;
      out_item_r.right_drive      <= right_nxt;
      out_item_r.drive_mode       <= mode_nxt;
      out_item_r.command_accepted <= !tick && cmd.accepted;
      out_item_r.checksum_error   <= !tick && cmd.bad_sum;
    end
  end

endmodule

FILE: rtl/mcdr_deframer.sv
// Serial byte deframer: header search, payload capture and checksum check.
`timescale 1ns / 1ps

module mcdr_deframer
  import mcdr_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output cmd_t       cmd
);

  localparam logic [3:0] CSUM_POS = 4'(FRAME_LENGTH - 3);
  localparam logic [3:0] LAST_POS = 4'(FRAME_LENGTH - 1);

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] csum_r;
  logic [7:0] payload_r [PAYLOAD_DEPTH];

  logic       in_payload;
  logic [2:0] pay_idx;
  logic       frame_done;
  logic       id_ok;

  assign in_payload = (pos_r >= 4'd2) && (pos_r <= 4'd7);
  assign pay_idx    = 3'(pos_r - 4'd2);
  assign frame_done = byte_en && (pos_r == LAST_POS);
  assign id_ok      = (payload_r[0] == CMD_ID_DRIVE);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (pos_r == 4'd0) begin
      if (rx_byte == HDR_BYTE0) begin
        sum_nxt = rx_byte;
        pos_nxt = 4'd1;
      end
    end else if (pos_r == 4'd1) begin
      if (rx_byte == HDR_BYTE1) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = 4'd2;
      end else begin
        pos_nxt = 4'd0;
      end
    end else begin
      if (pos_r < CSUM_POS) sum_nxt = sum_r + rx_byte;
      pos_nxt = (pos_r == LAST_POS) ? 4'd0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (byte_en) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // payload and checksum byte hold no reset; all are written before a frame completes
  always_ff @(posedge clk) begin
    if (byte_en && in_payload) payload_r[pay_idx] <= rx_byte;
    if (byte_en && pos_r == CSUM_POS && pos_r >= 4'd2) csum_r <= rx_byte;
  end

  always_comb begin
    cmd.accepted = frame_done && id_ok && (csum_r == sum_r);
    cmd.bad_sum  = frame_done && id_ok && (csum_r != sum_r);
    cmd.mode     = payload_r[1];
    cmd.left     = {payload_r[3], payload_r[2]};
    cmd.right    = {payload_r[5], payload_r[4]};
  end

endmodule

FILE: rtl/mcdr_ramp.sv
// Drive targets, slew-limited current values, ramp timer and command timeout.
`timescale 1ns / 1ps

module mcdr_ramp
  import mcdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_en,
  input  logic               tick,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  output logic signed [15:0] left_nxt,
  output logic signed [15:0] right_nxt,
  output logic [7:0]         mode_nxt
);

  logic signed [15:0] left_tgt_r, right_tgt_r, left_cur_r, right_cur_r;
  logic signed [15:0] left_tgt_nxt, right_tgt_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        age_r, age_nxt;
  logic [7:0]         mode_r;

  logic [16:0]        age_inc;
  logic               expired;
  logic [15:0]        elapsed_inc;
  logic signed [15:0] lim_pos, lim_neg;

  function automatic logic signed [15:0] ramp_toward(
    input logic signed [15:0] cur,
    input logic signed [15:0] tgt,
    input logic [7:0]         st
  );
    logic signed [17:0] up, dn, t;
    logic signed [15:0] res;
    begin
      t   = 18'(tgt);
      up  = 18'(cur) + 18'(st);
      dn  = 18'(cur) - 18'(st);
      res = cur;
      if (cur < tgt) res = (up > t) ? tgt : up[15:0];
      else if (cur > tgt) res = (dn < t) ? tgt : dn[15:0];
      return res;
    end
  endfunction

  function automatic logic signed [15:0] clamp(
    input logic signed [15:0] v,
    input logic signed [15:0] hi,
    input logic signed [15:0] lo
  );
    begin
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    end
  endfunction

  assign lim_pos     = {1'b0, cfg.speed_limit};
  assign lim_neg     = -lim_pos;
  assign age_inc     = {1'b0, age_r} + 17'd1;
  assign expired     = age_inc > {1'b0, cfg.command_timeout};
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    left_tgt_nxt  = left_tgt_r;
    right_tgt_nxt = right_tgt_r;
    left_nxt      = left_cur_r;
    right_nxt     = right_cur_r;
    elapsed_nxt   = elapsed_r;
    age_nxt       = age_r;
    mode_nxt      = mode_r;
    if (tick) begin
      age_nxt = age_inc[16] ? 16'hFFFF : age_inc[15:0];
      if (elapsed_inc >= cfg.step_period) begin
        left_nxt    = ramp_toward(left_cur_r, left_tgt_r, cfg.step_size);
        right_nxt   = ramp_toward(right_cur_r, right_tgt_r, cfg.step_size);
        elapsed_nxt = '0;
      end else begin
        elapsed_nxt = elapsed_inc;
      end
      // timeout stop: targets drop, currents ramp down from here
      if (expired && (left_tgt_r != 16'sd0 || right_tgt_r != 16'sd0)) begin
        left_tgt_nxt  = '0;
        right_tgt_nxt = '0;
        age_nxt       = '0;
      end
    end else if (cmd.accepted) begin
      mode_nxt = cmd.mode;
      if (cmd.mode == DRIVE_MODE_STOP) begin
        left_tgt_nxt  = '0;
        right_tgt_nxt = '0;
        left_nxt      = '0;
        right_nxt     = '0;
      end else begin
        left_tgt_nxt  = clamp(cmd.left, lim_pos, lim_neg);
        right_tgt_nxt = clamp(cmd.right, lim_pos, lim_neg);
        age_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_tgt_r  <= '0;
      right_tgt_r <= '0;
      left_cur_r  <= '0;
      right_cur_r <= '0;
      elapsed_r   <= '0;
      age_r       <= '0;
      mode_r      <= '0;
    end else if (item_en) begin
      left_tgt_r  <= left_tgt_nxt;
      right_tgt_r <= right_tgt_nxt;
      left_cur_r  <= left_nxt;
      right_cur_r <= right_nxt;
      elapsed_r   <= elapsed_nxt;
      age_r       <= age_nxt;
      mode_r      <= mode_nxt;
    end
  end

endmodule
